// ----- rtl/looping_pattern_recorder_defines.svh -----
// Assertion macros for the looping pattern recorder.
// Included by the top level; compiled to nothing when SYNTHESIS is defined.
`ifndef LOOPING_PATTERN_RECORDER_DEFINES_SVH
`define LOOPING_PATTERN_RECORDER_DEFINES_SVH

`ifndef SYNTHESIS

`define LPR_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPR_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg)

`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/lpr_pkg.sv -----
// Shared constants, types and codes of the looping pattern recorder.
// Used by lpr_slot_store, looping_pattern_recorder, lpr_checker and testbench; depends on nothing.
package lpr_pkg;

    localparam int RING_STEPS = 16;
    localparam int CHANNELS   = 8;
    localparam int WORD_BITS  = 32;

    localparam int STEP_W     = $clog2(RING_STEPS);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W     = STEP_W + CH_W;
    localparam int SLOT_COUNT = RING_STEPS << CH_W;

    localparam int ROLL_W     = 7;
    localparam int ROLLS_W    = ROLL_W * CHANNELS;

    localparam int KIND_W     = 2;
    localparam int CHAN_IN_W  = 4;
    localparam int PAYLOAD_W  = 32;
    localparam int ROLLS_IN_W = 56;
    localparam int OUT_CH_W   = 3;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 40;

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [ROLL_W-1:0] FULL_CHANCE = 7'd100;

    localparam logic [1:0] REG_LOOP_START  = 2'd0;
    localparam logic [1:0] REG_LOOP_END    = 2'd1;
    localparam logic [1:0] REG_PLAY_CHANCE = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECORD = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_TOGGLE = 2'd2
    } t_kind;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [STEP_W-1:0]    t_step;
    typedef logic [CH_W-1:0]      t_ch;

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        logic  clr_en;
        t_step step;
        t_ch   ch;
    } t_store_cmd;

endpackage

// ----- rtl/lpr_slot_store.sv -----
// Slot store: event word memory with one port and per-slot filled flags.
// Depends on lpr_pkg; a row clear drops the filled flags of one step.
module lpr_slot_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpr_pkg::t_store_cmd i_cmd,
    input  lpr_pkg::t_word     i_wr_word,
    output lpr_pkg::t_word     o_rd_word,
    output logic               o_rd_filled
);
    import lpr_pkg::*;

    t_word                 r_mem [SLOT_COUNT];
    t_word                 r_rd_word;
    logic                  r_rd_filled;
    logic [SLOT_COUNT-1:0] r_filled;
    logic [SLOT_COUNT-1:0] n_filled;
    logic [ADDR_W-1:0]     addr;

    assign addr = {i_cmd.step, i_cmd.ch};

    always_comb begin
        n_filled = r_filled;
        if (i_cmd.wr_en) begin
            n_filled[addr] = 1'b1;
        end
        if (i_cmd.clr_en) begin
            for (int c = 0; c < CHANNELS; c++) begin
                n_filled[{i_cmd.step, CH_W'(c)}] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= i_wr_word;
        end
        if (i_cmd.rd_en) begin
            r_rd_word   <= r_mem[addr];
            r_rd_filled <= r_filled[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else begin
            r_filled <= n_filled;
        end
    end

    // empty slots read as zero
    assign o_rd_word   = r_rd_filled ? r_rd_word : '0;
    assign o_rd_filled = r_rd_filled;

endmodule

// ----- rtl/looping_pattern_recorder.sv -----
// Looping pattern recorder: a store of 16 steps by 8 channels of 32-bit event words. Record
// beats, record-mode ticks and mode toggles complete when accepted. A play-mode tick is
// accepted in idle, then walks the channels in turn through the single chance comparator and
// the slot memory read port, then releases any final beat with tlast in the flush state; a
// result port that holds m_tready low can stall the walk and the flush. s_tready is high
// only between items. Filled flags are flip-flops cleared by reset, so no clearing pass runs.
// Depends on lpr_pkg, lpr_slot_store and looping_pattern_recorder_defines.svh.
`include "looping_pattern_recorder_defines.svh"

module looping_pattern_recorder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lpr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lpr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // channel[3:0], payload[35:4], chance_rolls[91:36], zero[95:92]
    input  logic [lpr_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [lpr_pkg::KIND_W-1:0]    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_channel[2:0], out_payload[34:3], zero[39:35]
    output logic [lpr_pkg::M_TDATA_W-1:0] m_tdata,
    // out_filled[0]
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import lpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state               r_state, n_state;
    logic [3:0]           r_loop_start, n_loop_start;
    logic [4:0]           r_loop_end, n_loop_end;
    logic [ROLL_W-1:0]    r_chance, n_chance;
    logic                 r_play_mode, n_play_mode;
    t_step                r_record_step, n_record_step;
    t_step                r_play_step, n_play_step;
    t_step                r_scan_step, n_scan_step;
    t_ch                  r_ch, n_ch;
    logic [ROLLS_W-1:0]   r_rolls, n_rolls;
    logic                 r_pend_v, n_pend_v;
    t_ch                  r_pend_ch, n_pend_ch;
    logic                 r_out_valid, n_out_valid;
    t_ch                  r_out_ch, n_out_ch;
    logic [PAYLOAD_W-1:0] r_out_payload, n_out_payload;
    logic                 r_out_filled, n_out_filled;
    logic                 r_out_last, n_out_last;

    t_store_cmd             store_cmd;
    t_word                  rd_word;
    logic                   rd_filled;
    logic                   cfg_wr;
    logic                   s_beat;
    logic                   out_free;
    logic                   pass;
    logic [CHAN_IN_W-1:0]   s_chan;
    logic [PAYLOAD_W-1:0]   s_payload;
    logic [ROLLS_IN_W-1:0]  s_rolls;
    logic [ROLL_W-1:0]      roll;
    t_step                  start_pos;
    logic [STEP_W:0]        play_next;
    logic [STEP_W:0]        record_next;

    assign s_chan    = s_tdata[CHAN_IN_W-1:0];
    assign s_payload = s_tdata[CHAN_IN_W+PAYLOAD_W-1:CHAN_IN_W];
    assign s_rolls   = s_tdata[CHAN_IN_W+PAYLOAD_W+ROLLS_IN_W-1:CHAN_IN_W+PAYLOAD_W];

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (r_state == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    // shared chance comparator, fed from the low end of the roll shifter
    assign roll = r_rolls[ROLL_W-1:0];
    assign pass = (r_chance == FULL_CHANCE) || (roll < r_chance);

    assign start_pos   = (32'(r_loop_start) >= RING_STEPS) ? '0 : STEP_W'(r_loop_start);
    assign play_next   = (STEP_W+1)'(r_play_step) + (STEP_W+1)'(1);
    assign record_next = (STEP_W+1)'(r_record_step) + (STEP_W+1)'(1);

    always_comb begin
        case (paddr[3:2])
            REG_LOOP_START:  prdata = PDATA_W'(r_loop_start);
            REG_LOOP_END:    prdata = PDATA_W'(r_loop_end);
            REG_PLAY_CHANCE: prdata = PDATA_W'(r_chance);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_loop_start  = r_loop_start;
        n_loop_end    = r_loop_end;
        n_chance      = r_chance;
        n_play_mode   = r_play_mode;
        n_record_step = r_record_step;
        n_play_step   = r_play_step;
        n_scan_step   = r_scan_step;
        n_ch          = r_ch;
        n_rolls       = r_rolls;
        n_pend_v      = r_pend_v;
        n_pend_ch     = r_pend_ch;
        n_out_valid   = r_out_valid && !m_tready;
        n_out_ch      = r_out_ch;
        n_out_payload = r_out_payload;
        n_out_filled  = r_out_filled;
        n_out_last    = r_out_last;
        store_cmd     = '0;

        if (cfg_wr) begin
            case (paddr[3:2])
                REG_LOOP_START:  n_loop_start = pwdata[3:0];
                REG_LOOP_END:    n_loop_end   = pwdata[4:0];
                REG_PLAY_CHANCE: n_chance     = pwdata[ROLL_W-1:0];
                default:         ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (s_beat) begin
                    case (t_kind'(s_tuser))
                        KIND_RECORD: begin
                            if (!r_play_mode && (s_chan inside {[1:CHANNELS]})) begin
                                store_cmd.wr_en = 1'b1;
                                store_cmd.step  = r_record_step;
                                store_cmd.ch    = CH_W'(s_chan - CHAN_IN_W'(1));
                            end
                        end
                        KIND_TICK: begin
                            if (!r_play_mode) begin
                                if (32'(record_next) >= RING_STEPS) begin
                                    n_record_step = '0;
                                end else begin
                                    n_record_step = STEP_W'(record_next);
                                end
                                store_cmd.clr_en = 1'b1;
                                store_cmd.step   = n_record_step;
                            end else begin
                                n_scan_step = r_play_step;
                                n_rolls     = ROLLS_W'(s_rolls);
                                n_ch        = '0;
                                n_state     = ST_SCAN;
                                if (32'(play_next) == 32'(r_loop_end)) begin
                                    n_play_step = start_pos;
                                end else if (32'(play_next) >= RING_STEPS) begin
                                    n_play_step = '0;
                                end else begin
                                    n_play_step = STEP_W'(play_next);
                                end
                            end
                        end
                        KIND_TOGGLE: begin
                            n_play_mode = !r_play_mode;
                            n_play_step = r_play_mode ? '0 : start_pos;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // hold the scan while a second hit waits on a full result register
                if (!(pass && r_pend_v && !out_free)) begin
                    if (pass) begin
                        store_cmd.rd_en = 1'b1;
                        store_cmd.step  = r_scan_step;
                        store_cmd.ch    = r_ch;
                        n_pend_v        = 1'b1;
                        n_pend_ch       = r_ch;
                        if (r_pend_v) begin
                            n_out_valid   = 1'b1;
                            n_out_ch      = r_pend_ch;
                            n_out_payload = PAYLOAD_W'(rd_word);
                            n_out_filled  = rd_filled;
                            n_out_last    = 1'b0;
                        end
                    end
                    n_rolls = r_rolls >> ROLL_W;
                    n_ch    = r_ch + CH_W'(1);
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_ch      = r_pend_ch;
                    n_out_payload = PAYLOAD_W'(rd_word);
                    n_out_filled  = rd_filled;
                    n_out_last    = 1'b1;
                    n_pend_v      = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_scan_step   <= n_scan_step;
        r_ch          <= n_ch;
        r_rolls       <= n_rolls;
        r_pend_ch     <= n_pend_ch;
        r_out_ch      <= n_out_ch;
        r_out_payload <= n_out_payload;
        r_out_filled  <= n_out_filled;
        r_out_last    <= n_out_last;
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_loop_start  <= '0;
            r_loop_end    <= '0;
            r_chance      <= FULL_CHANCE;
            r_play_mode   <= 1'b0;
            r_record_step <= '0;
            r_play_step   <= '0;
            r_pend_v      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_loop_start  <= n_loop_start;
            r_loop_end    <= n_loop_end;
            r_chance      <= n_chance;
            r_play_mode   <= n_play_mode;
            r_record_step <= n_record_step;
            r_play_step   <= n_play_step;
            r_pend_v      <= n_pend_v;
            r_out_valid   <= n_out_valid;
        end
    end

    lpr_slot_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (store_cmd),
        .i_wr_word   (t_word'(s_payload)),
        .o_rd_word   (rd_word),
        .o_rd_filled (rd_filled)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_TDATA_W-OUT_CH_W-PAYLOAD_W)'(0), r_out_payload, OUT_CH_W'(r_out_ch)};
    assign m_tuser  = r_out_filled;
    assign m_tlast  = r_out_last;

    `LPR_ASSERT_HOLDS(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_v, "pending hit left in idle")
    `LPR_ASSERT_HOLDS(a_scan_in_play, i_clk, i_rst_n, r_state != ST_IDLE, r_play_mode, "scan outside play mode")
    `LPR_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n, (r_state == ST_FLUSH) && r_pend_v && out_free, r_out_valid && r_out_last && (r_state == ST_IDLE), "final beat not released")

endmodule

// ----- tb/sv/lpr_checker.sv -----
// Result checker for the looping pattern recorder: follows APB writes and input beats,
// predicts the emitted slot beats and compares them with the result stream.
// Depends on lpr_pkg; instantiated by testbench.
module lpr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpr_pkg::PADDR_W-1:0]     paddr,
    input  logic [lpr_pkg::PDATA_W-1:0]     pwdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lpr_pkg::KIND_W-1:0]      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lpr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpr_pkg::*;

    typedef struct packed {
        logic [OUT_CH_W-1:0] channel;
        t_word               word;
        logic                filled;
        logic                last;
    } t_slot_emit;

    logic [3:0]        loop_start;
    logic [4:0]        loop_end;
    logic [ROLL_W-1:0] play_chance;

    logic  play_mode;
    t_step rec_step;
    t_step play_step;
    t_word slot_word [SLOT_COUNT];
    logic  slot_filled [SLOT_COUNT];

    t_slot_emit emits_due [$];
    int         fails = 0;

    function automatic t_step loop_entry();
        if (loop_start >= RING_STEPS) return '0;
        return loop_start[STEP_W-1:0];
    endfunction

    task automatic apply_pattern_item(input logic [KIND_W-1:0]     kind,
                                      input logic [CHAN_IN_W-1:0]  chan,
                                      input logic [PAYLOAD_W-1:0]  word,
                                      input logic [ROLLS_IN_W-1:0] rolls);
        int                base;
        logic [CHANNELS-1:0] pass;
        logic [STEP_W:0]   next;
        logic [ROLL_W-1:0] roll;
        t_slot_emit        e;
        case (kind)
            KIND_RECORD: begin
                if (!play_mode && chan >= 1 && chan <= CHANNELS) begin
                    base = int'(rec_step) * CHANNELS + int'(chan) - 1;
                    slot_word[base]   = word[WORD_BITS-1:0];
                    slot_filled[base] = 1'b1;
                end
            end
            KIND_TICK: begin
                if (!play_mode) begin
                    rec_step = (int'(rec_step) + 1 >= RING_STEPS) ? '0 : rec_step + 1'b1;
                    base = int'(rec_step) * CHANNELS;
                    for (int i = 0; i < CHANNELS; i++) begin
                        slot_word[base + i]   = '0;
                        slot_filled[base + i] = 1'b0;
                    end
                end else begin
                    base = int'(play_step) * CHANNELS;
                    for (int i = 0; i < CHANNELS; i++) begin
                        roll    = rolls[ROLL_W*i +: ROLL_W];
                        pass[i] = (play_chance == FULL_CHANCE) || (roll < play_chance);
                    end
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (pass[i]) begin
                            e.channel = OUT_CH_W'(i);
                            e.word    = slot_word[base + i];
                            e.filled  = slot_filled[base + i];
                            e.last    = ((pass >> (i + 1)) == '0);
                            emits_due = {emits_due, e};
                        end
                    end
                    next = {1'b0, play_step} + 1'b1;
                    if (next == loop_end) play_step = loop_entry();
                    else if (next >= RING_STEPS) play_step = '0;
                    else play_step = next[STEP_W-1:0];
                end
            end
            KIND_TOGGLE: begin
                play_mode = !play_mode;
                play_step = play_mode ? loop_entry() : '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_slot_emit e;
        if (!i_rst_n) begin
            loop_start  = '0;
            loop_end    = '0;
            play_chance = FULL_CHANCE;
            play_mode   = 1'b0;
            rec_step    = '0;
            play_step   = '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_word[i]   = '0;
                slot_filled[i] = 1'b0;
            end
            emits_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_LOOP_START:  loop_start  = pwdata[3:0];
                    REG_LOOP_END:    loop_end    = pwdata[4:0];
                    REG_PLAY_CHANCE: play_chance = pwdata[ROLL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_pattern_item(s_tuser, s_tdata[CHAN_IN_W-1:0],
                                   s_tdata[CHAN_IN_W +: PAYLOAD_W],
                                   s_tdata[CHAN_IN_W+PAYLOAD_W +: ROLLS_IN_W]);
            if (m_tvalid && m_tready) begin
                if (emits_due.size() == 0) begin
                    $error("unexpected result beat: channel %0d payload %h",
                           m_tdata[OUT_CH_W-1:0], m_tdata[OUT_CH_W +: PAYLOAD_W]);
                    fails++;
                end else begin
                    e = emits_due.pop_front();
                    if (m_tdata[OUT_CH_W-1:0] !== e.channel) begin
                        $error("out_channel: expected %0d, actual %0d",
                               e.channel, m_tdata[OUT_CH_W-1:0]);
                        fails++;
                    end
                    if (m_tdata[OUT_CH_W +: PAYLOAD_W] !== e.word) begin
                        $error("out_payload: expected %h, actual %h",
                               e.word, m_tdata[OUT_CH_W +: PAYLOAD_W]);
                        fails++;
                    end
                    if (m_tuser !== e.filled) begin
                        $error("out_filled: expected %0b, actual %0b", e.filled, m_tuser);
                        fails++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("out_last: expected %0b, actual %0b", e.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= emits_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the looping pattern recorder testbench: clock, reset, APB writes, input beats
// and result back-pressure, with the verdict. Depends on lpr_pkg, lpr_checker and the
// looping_pattern_recorder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lpr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 14;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 48;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int fail_count;
    int pending;
    bit quiet = 1'b0;

    looping_pattern_recorder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lpr_checker pattern_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [KIND_W-1:0]     kind,
                             input logic [CHAN_IN_W-1:0]  chan,
                             input logic [PAYLOAD_W-1:0]  word,
                             input logic [ROLLS_IN_W-1:0] rolls);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({rolls, word, chan});
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // drop valid, drain all results, then give a silent play tick time to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int                     pick;
        logic [63:0]            r64;
        logic [ROLLS_IN_W-1:0]  rolls;
        pick  = $urandom_range(0, 99);
        r64   = {$urandom, $urandom};
        rolls = r64[ROLLS_IN_W-1:0];
        if ($urandom_range(0, 9) == 0) rolls = $urandom_range(0, 1) ? '1 : '0;
        if (pick < 3)
            send_item(KIND_SPARE, CHAN_IN_W'($urandom), $urandom, rolls);
        else if (pick < 7)
            send_item(KIND_RECORD, CHAN_IN_W'(pick < 5 ? 0 : $urandom_range(9, 15)),
                      $urandom, rolls);
        else if (pick < 50)
            send_item(KIND_RECORD, CHAN_IN_W'($urandom_range(1, CHANNELS)), $urandom, rolls);
        else if (pick < 90)
            send_item(KIND_TICK, CHAN_IN_W'($urandom), $urandom, rolls);
        else
            send_item(KIND_TOGGLE, CHAN_IN_W'($urandom), $urandom, rolls);
    endtask

    initial begin : stimulus
        int start_v;
        int end_v;
        int chance_v;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_RECORD, 4'd1, 32'h0000_0000, '0);
        send_item(KIND_RECORD, 4'd8, 32'hFFFF_FFFF, '1);
        send_item(KIND_RECORD, 4'd4, 32'hA5A5_A5A5, '0);
        send_item(KIND_RECORD, 4'd0, 32'h1111_1111, '0);
        send_item(KIND_RECORD, 4'd9, 32'h2222_2222, '0);
        send_item(KIND_RECORD, 4'd15, 32'h3333_3333, '0);
        send_item(KIND_SPARE, 4'd15, 32'hFFFF_FFFF, '1);
        send_item(KIND_TICK, '0, '0, '0);
        send_item(KIND_RECORD, 4'd2, 32'h1234_5678, '0);
        send_item(KIND_TOGGLE, '0, '0, '0);
        send_item(KIND_TICK, '0, '0, '1);
        send_item(KIND_RECORD, 4'd3, 32'hDEAD_BEEF, '0);
        send_item(KIND_TICK, '0, '0, '0);
        send_item(KIND_TOGGLE, '0, '0, '0);
        settle();
        write_reg(REG_LOOP_START, 32'd15);
        write_reg(REG_LOOP_END, 32'd16);
        write_reg(REG_PLAY_CHANCE, 32'd0);
        send_item(KIND_TOGGLE, '0, '0, '0);
        send_item(KIND_TICK, '0, '0, '0);
        settle();
        write_reg(REG_LOOP_START, 32'd0);
        write_reg(REG_LOOP_END, 32'd1);
        write_reg(REG_PLAY_CHANCE, 32'd127);
        send_item(KIND_TICK, '0, '0, '1);
        send_item(KIND_TICK, '0, '0, {4{7'd127, 7'd0}});
        settle();
        write_reg(REG_LOOP_END, 32'd0);
        write_reg(REG_PLAY_CHANCE, 32'd1);
        send_item(KIND_TICK, '0, '0, {{7{7'd1}}, 7'd0});
        send_item(KIND_TOGGLE, '0, '0, '0);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            quiet    = (phase % 3 == 1);
            start_v  = (phase == 0) ? 0 : (phase == 1) ? 15 : $urandom_range(0, 15);
            end_v    = (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 16 : $urandom_range(0, 16);
            chance_v = (phase == 0) ? 100 : (phase == 1) ? 127 : (phase == 2) ? 0
                     : $urandom_range(1, 127);
            write_reg(REG_LOOP_START, start_v);
            write_reg(REG_LOOP_END, end_v);
            write_reg(REG_PLAY_CHANCE, chance_v);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && phase % 2 == 0) settle();
                random_item();
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
